>>> rtl/adsr_envelope_generator_unit_assert.svh
// Assertion macros for the envelope generator.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define ADSR_EG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ADSR_EG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/adsr_eg_pkg.sv
`default_nettype none

package adsr_eg_pkg;

    // Field and datapath widths
    localparam int SEGMENT_COUNT = 4;
    localparam int RATE_W        = 16;
    localparam int DUR_W         = 16;
    localparam int END_W         = 8;
    localparam int LEVEL_W       = 8;
    localparam int SEG_W         = 2;
    localparam int FRAC_W        = 8;
    localparam int PHASE_W       = 32;
    localparam int BOUND_W       = 24;
    localparam int PROD_W        = RATE_W + DUR_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_END     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_END      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_END    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_END    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd6;

    // Register reset values
    localparam logic [RATE_W-1:0]  RST_CONTROL_RATE   = 16'd1000;
    localparam logic [DUR_W-1:0]   RST_TOTAL_DURATION = 16'd256;
    localparam logic [END_W-1:0]   RST_ATTACK_END     = 8'd64;
    localparam logic [END_W-1:0]   RST_DECAY_END      = 8'd128;
    localparam logic [END_W-1:0]   RST_SUSTAIN_END    = 8'd192;
    localparam logic [END_W-1:0]   RST_RELEASE_END    = 8'd255;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL  = 8'd128;

    typedef enum logic [SEG_W-1:0] {
        SEG_ATTACK  = 2'd0,
        SEG_DECAY   = 2'd1,
        SEG_SUSTAIN = 2'd2,
        SEG_RELEASE = 2'd3
    } seg_t;

    // Bound recompute sequencer
    typedef enum logic [1:0] {
        BND_IDLE,
        BND_LOAD,
        BND_TOTAL,
        BND_SEG
    } bnd_state_t;

    // Per-tick sequencer
    typedef enum logic [2:0] {
        TK_IDLE,
        TK_ADV,
        TK_SETUP,
        TK_CHECK,
        TK_DIV,
        TK_LEVEL,
        TK_HOLD
    } tick_state_t;

    // Status from the bound unit to the tick sequencer
    typedef struct packed {
        logic                                    busy;
        logic [LEVEL_W-1:0]                      sustain;
        logic [SEGMENT_COUNT-1:0][BOUND_W-1:0]   bound;
    } bnd_status_t;

endpackage

`default_nettype wire

>>> rtl/adsr_eg_if.sv
`default_nettype none

// Tick channel: one beat per control-rate tick
interface adsr_eg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Envelope result channel
interface adsr_eg_env_if import adsr_eg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [SEG_W-1:0]   segment_now;

    modport source (output valid, output level, output segment_now, input ready);
    modport sink   (input valid, input level, input segment_now, output ready);
endinterface

// Configuration write channel
interface adsr_eg_cfg_if import adsr_eg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/adsr_envelope_generator_unit.sv
// ADSR envelope generator.
// Channels: tick (sink) carries one beat per control-rate tick with a
// restart flag; env (source) returns one beat per tick with the 8-bit
// level and the current segment; cfg (sink) writes the seven registers
// by index, ready always high, unknown indexes ignored.
// Each tick runs from accept through these steps: the accept, stepping
// through the segment bounds one segment at a time, the setup states
// SETUP and CHECK, a restoring divider for the ramp fraction (eight
// quotient bits, then done; skipped when the segment is empty or
// done), a level state and a result state.
// A new tick is accepted only once the last result has left HOLD.
// Segment bounds are rebuilt by a bit-serial multiplier after reset and
// after every cfg beat; tick ready is low meanwhile.
// Reset: phase 0, attack segment, level 255, registers at defaults.
// The result sits in an output register; a new tick is accepted while a
// stalled result waits, and the next result waits until env is taken.
`default_nettype none

`include "adsr_envelope_generator_unit_assert.svh"

module adsr_envelope_generator_unit import adsr_eg_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    adsr_eg_cfg_if.sink     cfg,
    adsr_eg_tick_if.sink    tick,
    adsr_eg_env_if.source   env
);

    bnd_status_t        bnd;

    tick_state_t        state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg;
    seg_t               seg_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [BOUND_W-1:0] dur_reg;
    logic [PHASE_W-1:0] sp_reg;
    logic [FRAC_W:0]    frac_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [SEG_W-1:0]   out_seg_reg;

    logic               accept;
    logic [PHASE_W-1:0] phase_base;
    logic [PHASE_W-1:0] phase_inc;
    logic [SEG_W-1:0]   seg_code_inc;
    logic [SEG_W-1:0]   seg_code_dec;
    logic [BOUND_W-1:0] cur_bound;
    logic [BOUND_W-1:0] last_bound;
    logic               advance;
    logic               full;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quo;
    logic [LEVEL_W-1:0] gain;
    logic [2*LEVEL_W:0] mul_full;
    logic [LEVEL_W-1:0] scaled;
    logic [LEVEL_W-1:0] level_calc;
    logic               out_load;

    adsr_eg_bounds u_bounds
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .status (bnd)
    );

    adsr_eg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sp_reg[BOUND_W-1:0]),
        .divisor  (dur_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Phase update and segment bound lookups
    always_comb
    begin
        accept       = tick.valid && tick.ready;
        phase_base   = tick.restart ? '0 : phase_reg;
        phase_inc    = (&phase_base) ? phase_base : phase_base + PHASE_W'(1);
        seg_code_inc = 2'(seg_reg) + SEG_W'(1);
        seg_code_dec = 2'(seg_reg) - SEG_W'(1);
        cur_bound    = bnd.bound[seg_reg];
        last_bound   = (seg_reg == SEG_ATTACK) ? '0 : bnd.bound[seg_code_dec];
        advance      = (seg_reg != SEG_RELEASE)
                    && (phase_reg >= {{(PHASE_W-BOUND_W){1'b0}}, cur_bound});
        full         = (dur_reg == '0)
                    || (sp_reg >= {{(PHASE_W-BOUND_W){1'b0}}, dur_reg});
    end

    // Level from the ramp fraction
    always_comb
    begin
        unique case (seg_reg)
            SEG_ATTACK:  gain = LEVEL_MAX;
            SEG_DECAY:   gain = LEVEL_MAX - bnd.sustain;
            SEG_SUSTAIN: gain = '0;
            SEG_RELEASE: gain = bnd.sustain;
            default:     gain = '0;
        endcase
        mul_full = (2*LEVEL_W+1)'(frac_reg) * (2*LEVEL_W+1)'(gain);
        scaled   = mul_full[2*LEVEL_W-1:FRAC_W];
        unique case (seg_reg)
            SEG_ATTACK:  level_calc = scaled;
            SEG_DECAY:   level_calc = LEVEL_MAX - scaled;
            SEG_SUSTAIN: level_calc = level_reg;
            SEG_RELEASE: level_calc = bnd.sustain - scaled;
            default:     level_calc = level_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TK_IDLE:  if (accept) state_next = TK_ADV;
            TK_ADV:   if (!advance) state_next = TK_SETUP;
            TK_SETUP: state_next = TK_CHECK;
            TK_CHECK: state_next = full ? TK_LEVEL : TK_DIV;
            TK_DIV:   if (div_done) state_next = TK_LEVEL;
            TK_LEVEL: state_next = TK_HOLD;
            TK_HOLD:  if (!out_valid_reg || env.ready) state_next = TK_IDLE;
            default:  state_next = TK_IDLE;
        endcase
    end

    // Handshake and control outputs
    always_comb
    begin
        tick.ready = (state_reg == TK_IDLE) && !bnd.busy;
        div_start  = (state_reg == TK_CHECK) && !full;
        out_load   = (state_reg == TK_HOLD) && (!out_valid_reg || env.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TK_IDLE;
            phase_reg     <= '0;
            seg_reg       <= SEG_ATTACK;
            level_reg     <= LEVEL_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                phase_reg <= phase_inc;
                if (tick.restart)
                    seg_reg <= SEG_ATTACK;
            end
            else if (state_reg == TK_ADV && advance)
                seg_reg <= seg_t'(seg_code_inc);
            if (state_reg == TK_LEVEL)
                level_reg <= level_calc;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (env.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Ramp datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == TK_SETUP)
        begin
            dur_reg <= (cur_bound > last_bound) ? cur_bound - last_bound : '0;
            if (phase_reg > {{(PHASE_W-BOUND_W){1'b0}}, last_bound})
                sp_reg <= phase_reg - {{(PHASE_W-BOUND_W){1'b0}}, last_bound};
            else
                sp_reg <= '0;
        end
        if (state_reg == TK_CHECK && full)
            frac_reg <= {1'b1, {FRAC_W{1'b0}}};
        else if (state_reg == TK_DIV && div_done)
            frac_reg <= {1'b0, div_quo};
        if (out_load)
        begin
            out_level_reg <= level_reg;
            out_seg_reg   <= 2'(seg_reg);
        end
    end

    assign env.valid       = out_valid_reg;
    assign env.level       = out_level_reg;
    assign env.segment_now = out_seg_reg;

    // Checks
    `ADSR_EG_ASSERT_NEXT(a_tick_phase, tick.valid && tick.ready,
        (state_reg == TK_ADV) && (phase_reg != '0), "phase zero after tick")
    `ADSR_EG_ASSERT_NEXT(a_restart_attack, tick.valid && tick.ready && tick.restart,
        seg_reg == SEG_ATTACK, "restart did not return to attack")
    `ADSR_EG_ASSERT_NEXT(a_cfg_rebuild, cfg.valid && cfg.ready, bnd.busy,
        "bounds not rebuilt after write")
    `ADSR_EG_ASSERT_SAME(a_frac_range, state_reg == TK_LEVEL,
        (frac_reg[FRAC_W] == 1'b0) || (frac_reg[FRAC_W-1:0] == '0), "ramp fraction above one")

endmodule

`default_nettype wire

>>> rtl/adsr_eg_bounds.sv
`default_nettype none

module adsr_eg_bounds import adsr_eg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    adsr_eg_cfg_if.sink   cfg,
    output bnd_status_t   status
);

    localparam int TOTAL_STEPS = DUR_W;
    localparam int SEG_STEPS   = END_W;
    localparam int STEP_W      = $clog2(TOTAL_STEPS);
    localparam int IDX_W       = $clog2(SEGMENT_COUNT);

    logic [RATE_W-1:0]  rate_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [END_W-1:0]   end_reg [SEGMENT_COUNT];
    logic [LEVEL_W-1:0] sus_reg;

    bnd_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [BOUND_W-1:0] total_reg;
    logic [SEGMENT_COUNT-1:0][BOUND_W-1:0] bound_reg;

    logic [RATE_W:0]    sum_total;
    logic [PROD_W-1:0]  total_step;
    logic [BOUND_W:0]   sum_seg;
    logic [PROD_W-1:0]  seg_step;
    logic               last_step;
    logic [IDX_W-1:0]   idx_inc;

    assign cfg.ready = 1'b1;

    // Register file, writes take effect whatever the sequencer does
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RST_CONTROL_RATE;
            dur_reg    <= RST_TOTAL_DURATION;
            end_reg[0] <= RST_ATTACK_END;
            end_reg[1] <= RST_DECAY_END;
            end_reg[2] <= RST_SUSTAIN_END;
            end_reg[3] <= RST_RELEASE_END;
            sus_reg    <= RST_SUSTAIN_LEVEL;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CONTROL_RATE:   rate_reg   <= cfg.data[RATE_W-1:0];
                CFG_TOTAL_DURATION: dur_reg    <= cfg.data[DUR_W-1:0];
                CFG_ATTACK_END:     end_reg[0] <= cfg.data[END_W-1:0];
                CFG_DECAY_END:      end_reg[1] <= cfg.data[END_W-1:0];
                CFG_SUSTAIN_END:    end_reg[2] <= cfg.data[END_W-1:0];
                CFG_RELEASE_END:    end_reg[3] <= cfg.data[END_W-1:0];
                CFG_SUSTAIN_LEVEL:  sus_reg    <= cfg.data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Shift-add steps: one multiplier bit per cycle, product shifts right
    always_comb
    begin
        sum_total  = {1'b0, prod_reg[PROD_W-1:DUR_W]}
                   + (prod_reg[0] ? {1'b0, rate_reg} : '0);
        total_step = {sum_total, prod_reg[DUR_W-1:1]};
        sum_seg    = {1'b0, prod_reg[PROD_W-1:END_W]}
                   + (prod_reg[0] ? {1'b0, total_reg} : '0);
        seg_step   = {sum_seg, prod_reg[END_W-1:1]};
        idx_inc    = idx_reg + IDX_W'(1);
        if (state_reg == BND_TOTAL)
            last_step = (step_reg == STEP_W'(TOTAL_STEPS - 1));
        else
            last_step = (step_reg == STEP_W'(SEG_STEPS - 1));
    end

    // Next state; any write restarts the recompute
    always_comb
    begin
        state_next = state_reg;
        if (cfg.valid)
            state_next = BND_LOAD;
        else
        begin
            unique case (state_reg)
                BND_IDLE:  state_next = BND_IDLE;
                BND_LOAD:  state_next = BND_TOTAL;
                BND_TOTAL: if (last_step) state_next = BND_SEG;
                BND_SEG:
                begin
                    if (last_step && idx_reg == IDX_W'(SEGMENT_COUNT - 1))
                        state_next = BND_IDLE;
                end
                default:   state_next = BND_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BND_LOAD;
        else
            state_reg <= state_next;
    end

    // Multiplier datapath: total = rate*duration>>8, bound = total*end>>8
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BND_LOAD:
            begin
                prod_reg <= {{(PROD_W-DUR_W){1'b0}}, dur_reg};
                step_reg <= '0;
            end
            BND_TOTAL:
            begin
                if (last_step)
                begin
                    total_reg <= total_step[PROD_W-1:FRAC_W];
                    prod_reg  <= {{(PROD_W-END_W){1'b0}}, end_reg[0]};
                    idx_reg   <= '0;
                    step_reg  <= '0;
                end
                else
                begin
                    prod_reg <= total_step;
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            BND_SEG:
            begin
                if (last_step)
                begin
                    bound_reg[idx_reg] <= seg_step[PROD_W-1:FRAC_W];
                    prod_reg <= {{(PROD_W-END_W){1'b0}}, end_reg[idx_inc]};
                    idx_reg  <= idx_inc;
                    step_reg <= '0;
                end
                else
                begin
                    prod_reg <= seg_step;
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.busy    = (state_reg != BND_IDLE);
        status.sustain = sus_reg;
        status.bound   = bound_reg;
    end

endmodule

`default_nettype wire

>>> rtl/adsr_eg_div.sv
`default_nettype none

// Restoring divider: (dividend << FRAC_W) / divisor, dividend < divisor.
// One quotient bit per cycle.
module adsr_eg_div import adsr_eg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BOUND_W-1:0] dividend,
    input  logic [BOUND_W-1:0] divisor,
    output logic               done,
    output logic [FRAC_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [BOUND_W-1:0] rem_reg;
    logic [BOUND_W-1:0] dvs_reg;
    logic [FRAC_W-1:0]  quo_reg;

    logic [BOUND_W:0]   rem_shift;
    logic [BOUND_W:0]   rem_diff;
    logic               fits;
    logic               last_bit;

    // One trial subtract per cycle
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        last_bit  = (cnt_reg == CNT_W'(FRAC_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_bit;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && last_bit)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_diff[BOUND_W-1:0] : rem_shift[BOUND_W-1:0];
            quo_reg <= {quo_reg[FRAC_W-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    import adsr_eg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TICK_TARGET = 1400;
    localparam int IDLE_PCT    = 26;
    localparam int SHOW_FAULTS = 10;

    // Index past the last register; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Envelope predictor and queue of levels still owed by the block
    class envelope_scoreboard;
        typedef struct {
            logic [LEVEL_W-1:0] level;
            seg_t               seg;
        } env_beat_t;

        logic [RATE_W-1:0]  rate;
        logic [DUR_W-1:0]   span;
        logic [END_W-1:0]   end_frac [SEGMENT_COUNT];
        logic [LEVEL_W-1:0] sus_level;
        logic [PHASE_W-1:0] phase;
        seg_t               seg;
        logic [LEVEL_W-1:0] lvl;
        logic [BOUND_W-1:0] bound [SEGMENT_COUNT];
        env_beat_t          env_due [$];
        int                 faults;

        function new();
            rate        = RST_CONTROL_RATE;
            span        = RST_TOTAL_DURATION;
            end_frac[0] = RST_ATTACK_END;
            end_frac[1] = RST_DECAY_END;
            end_frac[2] = RST_SUSTAIN_END;
            end_frac[3] = RST_RELEASE_END;
            sus_level   = RST_SUSTAIN_LEVEL;
            phase       = '0;
            seg         = SEG_ATTACK;
            lvl         = LEVEL_MAX;
            faults      = 0;
            rebuild_bounds();
        endfunction

        // End tick of each segment from rate, duration and end fractions
        function void rebuild_bounds();
            logic [31:0] total;
            total = (32'(rate) * 32'(span)) >> FRAC_W;
            foreach (end_frac[i])
                bound[i] = BOUND_W'((40'(total) * 40'(end_frac[i])) >> FRAC_W);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CONTROL_RATE:   rate        = data;
                CFG_TOTAL_DURATION: span        = data;
                CFG_ATTACK_END:     end_frac[0] = data[END_W-1:0];
                CFG_DECAY_END:      end_frac[1] = data[END_W-1:0];
                CFG_SUSTAIN_END:    end_frac[2] = data[END_W-1:0];
                CFG_RELEASE_END:    end_frac[3] = data[END_W-1:0];
                CFG_SUSTAIN_LEVEL:  sus_level   = data[LEVEL_W-1:0];
                default:            return;
            endcase
            rebuild_bounds();
        endfunction

        // Advance the envelope by one tick and queue the level it gives
        function void take_tick(bit restart);
            logic [31:0] cur, last, len, into, frac;
            env_beat_t   beat;
            if (restart)
            begin
                phase = '0;
                seg   = SEG_ATTACK;
            end
            if (phase != '1)
                phase = phase + 32'd1;
            // several segments may be passed in one tick, never release
            while (seg != SEG_RELEASE && phase >= 32'(bound[seg]))
                seg = seg_t'(seg + 2'd1);

            cur  = 32'(bound[seg]);
            last = (seg == SEG_ATTACK) ? 32'd0 : 32'(bound[seg - 2'd1]);
            len  = (cur > last) ? cur - last : 32'd0;
            into = (phase > last) ? phase - last : 32'd0;
            // empty or finished segment sits at its end value
            if (len == 0 || into >= len)
                frac = 32'd256;
            else
                frac = 32'(({32'd0, into} << FRAC_W) / {32'd0, len});

            case (seg)
                SEG_ATTACK:  lvl = LEVEL_W'((frac * 32'(LEVEL_MAX)) >> FRAC_W);
                SEG_DECAY:   lvl = LEVEL_W'(32'(LEVEL_MAX) -
                                 ((frac * (32'(LEVEL_MAX) - 32'(sus_level))) >> FRAC_W));
                SEG_RELEASE: lvl = LEVEL_W'(32'(sus_level) -
                                 ((frac * 32'(sus_level)) >> FRAC_W));
                default:     ; // sustain holds whatever level was there
            endcase

            beat.level = lvl;
            beat.seg   = seg;
            env_due.push_back(beat);
        endfunction

        function void note_fault(string what);
            faults++;
            if (faults <= SHOW_FAULTS)
                $display("[%0t] envelope mismatch: %s", $realtime, what);
        endfunction

        function void check_env(logic [LEVEL_W-1:0] level, logic [SEG_W-1:0] segment);
            env_beat_t due;
            if (env_due.size() == 0)
            begin
                note_fault($sformatf("unexpected beat level %0d segment %0d", level, segment));
                return;
            end
            due = env_due.pop_front();
            if (level !== due.level || segment !== due.seg)
                note_fault($sformatf("level exp %0d got %0d, segment exp %0d got %0d",
                                     due.level, level, due.seg, segment));
        endfunction

        function int pending();
            return env_due.size();
        endfunction

        function void close_out();
            if (env_due.size() != 0)
                note_fault($sformatf("%0d beats never arrived", env_due.size()));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    adsr_eg_cfg_if  cfg_ch ();
    adsr_eg_tick_if tick_ch ();
    adsr_eg_env_if  env_ch ();

    adsr_envelope_generator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .tick  (tick_ch),
        .env   (env_ch)
    );

    envelope_scoreboard sb = new();

    bit no_idle;
    int env_hold_req;
    int ticks_sent;
    int cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random back-pressure, long holds on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        env_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (env_ch.valid === 1'b1 && env_ch.ready === 1'b1)
                sb.check_env(env_ch.level, env_ch.segment_now);
            if (env_hold_req > 0)
            begin
                hold_left    = env_hold_req;
                env_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                env_ch.ready <= 1'b0;
            end
            else
                env_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // One tick beat; valid stays up between back-to-back beats
    task automatic send_tick(input bit restart);
        // configuration beats are over once ticks resume
        cfg_ch.valid <= 1'b0;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart;
        @(posedge clk);
        while (tick_ch.ready !== 1'b1)
            @(posedge clk);
        sb.take_tick(restart);
        ticks_sent++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cfg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Stop offering ticks and wait for every owed level
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // New register setting: mostly a full, ordered envelope of modest length
    task automatic random_setting(output bit full);
        logic [END_W-1:0]      pts [SEGMENT_COUNT];
        logic [END_W-1:0]      t;
        logic [CFG_IDX_W-1:0]  idx;
        int                    mode;
        mode = $urandom_range(0, 9);
        full = (mode < 7);
        if (full)
        begin
            if (mode == 0)
            begin
                write_cfg(CFG_CONTROL_RATE, CFG_DATA_W'($urandom));
                write_cfg(CFG_TOTAL_DURATION, CFG_DATA_W'($urandom));
            end
            else
            begin
                write_cfg(CFG_CONTROL_RATE, CFG_DATA_W'($urandom_range(1, 48)));
                write_cfg(CFG_TOTAL_DURATION, CFG_DATA_W'($urandom_range(16, 768)));
            end
            foreach (pts[i])
                pts[i] = END_W'($urandom);
            // ascending end points except now and then
            if (mode != 1)
                for (int a = 0; a < SEGMENT_COUNT - 1; a++)
                    for (int b = 0; b < SEGMENT_COUNT - 1 - a; b++)
                        if (pts[b] > pts[b+1])
                        begin
                            t        = pts[b];
                            pts[b]   = pts[b+1];
                            pts[b+1] = t;
                        end
            // upper data bits are junk the block must drop
            write_cfg(CFG_ATTACK_END,  {END_W'($urandom), pts[0]});
            write_cfg(CFG_DECAY_END,   {END_W'($urandom), pts[1]});
            write_cfg(CFG_SUSTAIN_END, {END_W'($urandom), pts[2]});
            write_cfg(CFG_RELEASE_END, {END_W'($urandom), pts[3]});
            case ($urandom_range(0, 3))
                0:       write_cfg(CFG_SUSTAIN_LEVEL, CFG_DATA_W'(0));
                1:       write_cfg(CFG_SUSTAIN_LEVEL, {8'($urandom), LEVEL_MAX});
                default: write_cfg(CFG_SUSTAIN_LEVEL, CFG_DATA_W'($urandom));
            endcase
        end
        else
        begin
            // a few registers changed under a running envelope
            repeat ($urandom_range(1, 3))
            begin
                idx = CFG_IDX_W'($urandom_range(0, 7));
                if ((idx == CFG_CONTROL_RATE || idx == CFG_TOTAL_DURATION) &&
                    $urandom_range(0, 3) != 0)
                    write_cfg(idx, CFG_DATA_W'($urandom_range(1, 600)));
                else
                    write_cfg(idx, CFG_DATA_W'($urandom));
            end
        end
    endtask

    // Stimulus
    initial
    begin
        int  phase_no;
        int  n;
        bit  full;
        rst_n           <= 1'b0;
        tick_ch.valid   <= 1'b0;
        tick_ch.restart <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        no_idle      = 1'b0;
        env_hold_req = 0;
        ticks_sent   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: restart of a fresh envelope, then a plain tick
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // zero rate: every segment empty, level pinned at end of release
        write_cfg(CFG_CONTROL_RATE, 16'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();

        // largest rate and duration, plus a write to the unused index
        write_cfg(CFG_CONTROL_RATE, 16'hFFFF);
        write_cfg(CFG_TOTAL_DURATION, 16'hFFFF);
        write_cfg(CFG_UNUSED, 16'hFFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();

        // empty attack, decay falling all the way to a zero sustain
        write_cfg(CFG_CONTROL_RATE, 16'd8);
        write_cfg(CFG_TOTAL_DURATION, 16'd256);
        write_cfg(CFG_ATTACK_END, 16'd0);
        write_cfg(CFG_DECAY_END, 16'd255);
        write_cfg(CFG_SUSTAIN_END, 16'd255);
        write_cfg(CFG_RELEASE_END, 16'd255);
        write_cfg(CFG_SUSTAIN_LEVEL, 16'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        // empty decay jumped over into sustain; release ends before it starts
        write_cfg(CFG_ATTACK_END, 16'd128);
        write_cfg(CFG_DECAY_END, 16'd128);
        write_cfg(CFG_RELEASE_END, 16'd64);
        write_cfg(CFG_SUSTAIN_LEVEL, 16'd255);
        send_tick(1'b1);
        repeat (7) send_tick(1'b0);
        settle();

        // stretch the envelope under a running release: phase before its start
        write_cfg(CFG_TOTAL_DURATION, 16'd2560);
        write_cfg(CFG_SUSTAIN_END, 16'd200);
        write_cfg(CFG_RELEASE_END, 16'd255);
        send_tick(1'b0);
        send_tick(1'b0);

        // random settings, each followed by a run of ticks
        phase_no = 0;
        while (ticks_sent < TICK_TARGET)
        begin
            settle();
            phase_no++;
            no_idle = (phase_no >= 12 && phase_no < 16);
            random_setting(full);
            n = $urandom_range(6, 60);
            if (phase_no == 5)
            begin
                // result side stalls long enough for ticks to back up
                env_hold_req = 300;
                n = 50;
            end
            send_tick(full ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0));
            repeat (n - 1)
                send_tick($urandom_range(0, 49) == 0);
        end

        settle();
        repeat (40) @(posedge clk);
        sb.close_out();
        if (sb.faults == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
